// ===== design/assert_macros.svh =====
// Assertion helpers used by the item table design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk_s, rstn, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk_s, rstn, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition");
`else
`define ASSERT_AT(lbl, clk_s, rstn, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn, cond)
`endif
`endif

// ===== design/pfit_pkg.sv =====
`timescale 1ns / 1ps
package pfit_pkg;

	localparam int ITEM_ENTRIES_DEF = 4096;
	localparam int COUNT_BITS_DEF   = 24;

	localparam int KIND_W  = 2;
	localparam int INDEX_W = 12;
	localparam int FIELD_W = 24;
	localparam int REG_W   = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OCCUR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SUPPORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD  = 2'd1;

	localparam logic [REG_W-1:0] MIN_SUPPORT_RST = 24'd1;
	localparam logic [REG_W-1:0] MAX_PERIOD_RST  = 24'hFFFFFF;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] item_index;
	} item_t;

	typedef struct packed {
		logic               present;
		logic [FIELD_W-1:0] occurrences;
		logic [FIELD_W-1:0] period;
		logic               qualifies;
	} result_t;

endpackage

// ===== design/pfit_store.sv =====
`timescale 1ns / 1ps
module pfit_store #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 73
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	output logic                     clearing
);
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;
	logic [AW-1:0]    clr_addr_q;
	logic             clearing_q;
	logic             we_m;
	logic [AW-1:0]    wa_m;
	logic [WIDTH-1:0] wd_m;

	// sweep writes an all-zero word (seen mark clear) into every entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR)
				clearing_q <= 1'b0;
		end
	end

	always_comb begin
		we_m = clearing_q ? 1'b1 : wr_en;
		wa_m = clearing_q ? clr_addr_q : wr_addr;
		wd_m = clearing_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we_m)
			mem[wa_m] <= wd_m;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

// ===== design/periodic_frequent_item_table.sv =====
`timescale 1ns / 1ps
// Per-item table for periodic-frequent mining.
// item channel: item_valid / item_stall / item_data. Kind begin bumps the
// transaction count, kind occurrence updates the item's entry, kind query
// reads it; unused kind is dropped. Only a query produces a result beat.
// result channel: result_valid / result_stall / result_data, held while
// stalled. A query's result passes stage s1 and is then registered in the output register.
// Throughput: one item per cycle while not stalled; each item does one
// read-modify-write of the single-port-read entry memory, with the write
// of the item ahead forwarded into the next read. A stalled result blocks
// only a query that finds the output register still full; item_stall then rises.
// Config: cfg_we / cfg_index / cfg_data; the user must write them only while idle, the block does not enforce it.
// Reset: after arst_n releases, the entry memory is swept clear entry by
// entry, and item_stall stays high until the sweep is done.
module periodic_frequent_item_table
	#(
	parameter int ITEM_ENTRIES = pfit_pkg::ITEM_ENTRIES_DEF,
	parameter int COUNT_BITS   = pfit_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  pfit_pkg::item_t                item_data,
	output logic                           result_valid,
	input  logic                           result_stall,
	output pfit_pkg::result_t              result_data,
	input  logic                           cfg_we,
	input  logic [pfit_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfit_pkg::REG_W-1:0]     cfg_data
);
	import pfit_pkg::*;
`include "assert_macros.svh"

	localparam int AW      = $clog2(ITEM_ENTRIES);
	localparam int CB      = COUNT_BITS;
	localparam int ENTRY_W = 1 + 3 * CB;
	localparam int CMP_W   = (CB > REG_W) ? CB : REG_W;

	logic [REG_W-1:0] min_support_q;
	logic [REG_W-1:0] max_period_q;
	logic [CB-1:0]    tc_q;

	logic              accept;
	logic              in_range;
	logic [AW-1:0]     addr;
	logic              clearing;
	logic [ENTRY_W-1:0] rd_data;
	logic              wr_en;
	logic [ENTRY_W-1:0] wr_data;

	logic               valid_s1;
	logic [KIND_W-1:0]  kind_s1;
	logic               in_range_s1;
	logic [AW-1:0]      addr_s1;
	logic               fwd_hit_s1;
	logic [ENTRY_W-1:0] fwd_data_s1;
	logic               s1_fire;

	logic [ENTRY_W-1:0] entry;
	logic               seen;
	logic [CB-1:0]      cnt;
	logic [CB-1:0]      gap;
	logic [CB-1:0]      last;
	logic [CB-1:0]      tail;
	logic [CB-1:0]      per;
	logic [CB-1:0]      cnt_inc;
	logic               ok;
	logic               hit;

	logic    res_valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_support_q <= MIN_SUPPORT_RST;
			max_period_q  <= MAX_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_SUPPORT: min_support_q <= cfg_data;
				REG_MAX_PERIOD:  max_period_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept   = item_valid && !item_stall;
	assign in_range = 32'(item_data.item_index) < 32'(ITEM_ENTRIES);
	assign addr     = AW'(item_data.item_index);

	pfit_store #(
		.DEPTH(ITEM_ENTRIES),
		.WIDTH(ENTRY_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (addr_s1),
		.wr_data  (wr_data),
		.clearing (clearing)
	);

	assign s1_fire = valid_s1 && (kind_s1 != KIND_QUERY || !res_valid_q || !result_stall);
	assign item_stall = clearing || (valid_s1 && !s1_fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (s1_fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= item_data.kind;
			in_range_s1 <= in_range;
			addr_s1     <= addr;
			fwd_hit_s1  <= wr_en && (addr_s1 == addr);
			fwd_data_s1 <= wr_data;
		end
	end

	always_comb begin
		entry   = fwd_hit_s1 ? fwd_data_s1 : rd_data;
		seen    = entry[ENTRY_W-1];
		cnt     = entry[3*CB-1:2*CB];
		gap     = entry[2*CB-1:CB];
		last    = entry[CB-1:0];
		tail    = tc_q - last;
		per     = (tail > gap) ? tail : gap;
		cnt_inc = (cnt == '1) ? cnt : cnt + 1'b1;
		hit     = in_range_s1 && seen;
		ok      = (CMP_W'(cnt) >= CMP_W'(min_support_q)) &&
			(CMP_W'(per) <= CMP_W'(max_period_q));
		wr_en   = s1_fire && kind_s1 == KIND_OCCUR && in_range_s1;
		if (seen)
			wr_data = {1'b1, cnt_inc, per, tc_q};
		else
			wr_data = {1'b1, CB'(1), tc_q, tc_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tc_q <= '0;
		else if (s1_fire && kind_s1 == KIND_BEGIN && tc_q != '1)
			tc_q <= tc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (s1_fire && kind_s1 == KIND_QUERY)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_fire && kind_s1 == KIND_QUERY) begin
			res_q.present     <= hit;
			res_q.occurrences <= hit ? FIELD_W'(cnt) : '0;
			res_q.period      <= hit ? FIELD_W'(per) : '0;
			res_q.qualifies   <= hit && ok;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	`ASSERT_NEVER(a_query_overwrite, clk, arst_n,
		s1_fire && kind_s1 == KIND_QUERY && res_valid_q && result_stall)
	`ASSERT_AT(a_tc_monotonic, clk, arst_n, 1'b1 |=> tc_q >= $past(tc_q))
	`ASSERT_AT(a_s1_hold, clk, arst_n,
		valid_s1 && !s1_fire |=> valid_s1 && $stable(addr_s1) && $stable(kind_s1))
	`ASSERT_NEVER(a_no_write_clear, clk, arst_n, clearing && wr_en)

endmodule

// ===== bench/periodic_frequent_item_table_tb.sv =====
`timescale 1ns / 1ps
module periodic_frequent_item_table_tb;
	import pfit_pkg::*;

	localparam int ENTRIES = ITEM_ENTRIES_DEF;
	localparam logic [FIELD_W-1:0] COUNT_MAX = {FIELD_W{1'b1}};
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item_data;
	logic result_valid;
	logic result_stall;
	result_t result_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;

	periodic_frequent_item_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data(item_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// predicted table
	logic [REG_W-1:0] min_support_reg;
	logic [REG_W-1:0] max_period_reg;
	logic [FIELD_W-1:0] txn_count;
	logic seen_tbl [ENTRIES];
	logic [FIELD_W-1:0] occ_tbl [ENTRIES];
	logic [FIELD_W-1:0] gap_tbl [ENTRIES];
	logic [FIELD_W-1:0] last_txn_tbl [ENTRIES];
	result_t pending_results [$];

	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	int max_gap = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int pool_bits = 4;

	task automatic update_table(input item_t it);
		result_t r;
		logic [FIELD_W-1:0] gap;
		int idx;
		idx = int'(it.item_index);
		case (it.kind)
			KIND_BEGIN: begin
				if (txn_count != COUNT_MAX)
					txn_count++;
			end
			KIND_OCCUR: begin
				if (!seen_tbl[idx]) begin
					seen_tbl[idx] = 1'b1;
					occ_tbl[idx] = FIELD_W'(1);
					gap_tbl[idx] = txn_count;
					last_txn_tbl[idx] = txn_count;
				end else begin
					gap = txn_count - last_txn_tbl[idx];
					if (occ_tbl[idx] != COUNT_MAX)
						occ_tbl[idx]++;
					if (gap > gap_tbl[idx])
						gap_tbl[idx] = gap;
					last_txn_tbl[idx] = txn_count;
				end
			end
			KIND_QUERY: begin
				r = '0;
				if (seen_tbl[idx]) begin
					gap = txn_count - last_txn_tbl[idx];
					r.present = 1'b1;
					r.occurrences = occ_tbl[idx];
					r.period = (gap > gap_tbl[idx]) ? gap : gap_tbl[idx];
					r.qualifies = (r.occurrences >= min_support_reg) &&
						(r.period <= max_period_reg);
				end
				pending_results.insert(pending_results.size(), r);
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx);
		item_t it;
		int gap;
		it.kind = kind;
		it.item_index = idx;
		item_valid <= 1'b1;
		item_data <= it;
		do @(posedge clk); while (item_stall);
		update_table(it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_random_item();
		logic [KIND_W-1:0] kind;
		logic [INDEX_W-1:0] idx;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			kind = KIND_BEGIN;
		else if (pick < 70)
			kind = KIND_OCCUR;
		else if (pick < 95)
			kind = KIND_QUERY;
		else
			kind = KIND_UNUSED;
		if ($urandom_range(0, 4) == 0)
			idx = INDEX_W'($urandom);
		else begin
			idx = INDEX_W'($urandom_range(0, (1 << pool_bits) - 1));
			if ($urandom_range(0, 1))
				idx = idx | ~((INDEX_W'(1) << pool_bits) - INDEX_W'(1));
		end
		send_item(kind, idx);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MIN_SUPPORT)
			min_support_reg = val;
		else if (idx == REG_MAX_PERIOD)
			max_period_reg = val;
		@(posedge clk);
	endtask

	task automatic test_directed();
		max_gap = 0;
		stall_pct = 0;
		send_item(KIND_QUERY, 12'd0);
		// occurrence before any transaction, then a repeat in the same one
		send_item(KIND_OCCUR, 12'd0);
		send_item(KIND_OCCUR, 12'd0);
		send_item(KIND_QUERY, 12'd0);
		send_item(KIND_BEGIN, 12'd0);
		send_item(KIND_BEGIN, 12'hFFF);
		send_item(KIND_OCCUR, 12'hFFF);
		send_item(KIND_OCCUR, 12'hFFF);
		send_item(KIND_UNUSED, 12'hFFF);
		send_item(KIND_QUERY, 12'hFFF);
		repeat (3) send_item(KIND_BEGIN, 12'h555);
		send_item(KIND_OCCUR, 12'd0);
		send_item(KIND_QUERY, 12'd0);
		send_item(KIND_QUERY, 12'hAAA);
		send_item(KIND_QUERY, 12'h555);
		send_item(KIND_UNUSED, 12'd0);
		send_item(KIND_QUERY, 12'hFFF);
		wait_idle();
		write_reg(REG_MIN_SUPPORT, '0);
		write_reg(REG_MAX_PERIOD, '0);
		send_item(KIND_QUERY, 12'd0);
		send_item(KIND_OCCUR, 12'hFFF);
		send_item(KIND_QUERY, 12'hFFF);
		wait_idle();
		write_reg(REG_MIN_SUPPORT, {REG_W{1'b1}});
		write_reg(REG_MAX_PERIOD, {REG_W{1'b1}});
		send_item(KIND_QUERY, 12'd0);
		wait_idle();
		// spare indexes must not disturb the registers
		write_reg(REG_SPARE_2, '0);
		write_reg(REG_SPARE_3, '0);
		send_item(KIND_QUERY, 12'hFFF);
		wait_idle();
		write_reg(REG_MIN_SUPPORT, MIN_SUPPORT_RST);
		write_reg(REG_MAX_PERIOD, MAX_PERIOD_RST);
	endtask

	task automatic test_config_sweep();
		logic [REG_W-1:0] sup [6];
		logic [REG_W-1:0] per [6];
		int bits [6];
		sup = '{24'd1, 24'd0, 24'd2, 24'd3, 24'hFFFFFF, 24'd0};
		per = '{24'hFFFFFF, 24'd0, 24'd4, 24'd8, 24'hFFFFFF, 24'd0};
		bits = '{4, 3, 1, 2, 4, 6};
		sup[5] = REG_W'($urandom);
		per[5] = REG_W'($urandom);
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			write_reg(REG_MIN_SUPPORT, sup[p]);
			write_reg(REG_MAX_PERIOD, per[p]);
			pool_bits = bits[p];
			max_gap = (p % 2) ? 6 : 2;
			stall_pct = (p % 3) * 35;
			repeat (70) send_random_item();
		end
		wait_idle();
		write_reg(REG_MIN_SUPPORT, REG_W'($urandom_range(1, 4)));
		write_reg(REG_MAX_PERIOD, REG_W'($urandom_range(1, 12)));
	endtask

	task automatic test_backpressure();
		pool_bits = 2;
		max_gap = 0;
		stall_pct = 0;
		hold_request = 400;
		for (int n = 0; n < 60; n++)
			send_item((n % 4 == 0) ? KIND_BEGIN : KIND_QUERY,
				INDEX_W'($urandom_range(0, 3)));
		wait_idle();
	endtask

	task automatic test_random_mix();
		pool_bits = 3;
		for (int n = 0; n < 120; n++) begin
			if (n % 40 == 0) begin
				max_gap = $urandom_range(0, 8);
				stall_pct = $urandom_range(0, 80);
			end
			send_random_item();
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (hold_request != hold_taken) begin
			hold_left = hold_request;
			hold_taken = hold_request;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
		input logic [FIELD_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, actual %p", $time, result_data);
			end else begin
				want = pending_results.pop_front();
				check_field("present", FIELD_W'(want.present),
					FIELD_W'(result_data.present));
				check_field("occurrences", want.occurrences, result_data.occurrences);
				check_field("period", want.period, result_data.period);
				check_field("qualifies", FIELD_W'(want.qualifies),
					FIELD_W'(result_data.qualifies));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL periodic_frequent_item_table");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid <= 1'b0;
		item_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		min_support_reg = MIN_SUPPORT_RST;
		max_period_reg = MAX_PERIOD_RST;
		txn_count = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			seen_tbl[i] = 1'b0;
			occ_tbl[i] = '0;
			gap_tbl[i] = '0;
			last_txn_tbl[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random_mix();
		wait_idle();
		if (errors == 0)
			$display("PASS periodic_frequent_item_table");
		else
			$display("FAIL periodic_frequent_item_table");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/pfit_pkg.sv
design/pfit_store.sv
design/periodic_frequent_item_table.sv
bench/periodic_frequent_item_table_tb.sv
